@@ rtl/core/cstt_pkg.sv @@
// ----------------------------------------------------------------------------
// cstt_pkg: shared types and constants
// Stage records passed along the divider and fraction cell chains.
// ----------------------------------------------------------------------------
package cstt_pkg;

    localparam int unsigned DATA_W     = 64;
    localparam int unsigned SCALE_BITS = 30;
    localparam int unsigned WHOLE_W    = 35;

    localparam logic [DATA_W-1:0] NS_PER_SEC = 64'd1000000000;
    // largest whole part whose product with NS_PER_SEC fits in 64 bits
    localparam logic [DATA_W-1:0] MAX_WHOLE  = 64'd18446744073;

    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] nq;    // dividend bits out on top, quotient bits in below
        logic [DATA_W-1:0] den;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] lat;
    } t_div_stage;

    typedef struct packed {
        logic                  vld;
        logic                  bad;
        logic [DATA_W-1:0]     den;
        logic [DATA_W-1:0]     rem;
        logic [DATA_W-1:0]     acc;   // residue modulo den
        logic [SCALE_BITS-1:0] fq;    // fraction quotient so far
        logic [WHOLE_W-1:0]    whole;
        logic [DATA_W-1:0]     ws;    // whole part times the scale bits seen so far
        logic [DATA_W-1:0]     lat;
    } t_frac_stage;

endpackage

@@ rtl/core/ceil_scaled_transfer_time_core.sv @@
// ----------------------------------------------------------------------------
// ceil_scaled_transfer_time_core: rounded-up transfer time
// duration = ceil(byte_count * 1e9 / bytes_per_second) + fixed_latency.
// ----------------------------------------------------------------------------
// Fully pipelined: a new transfer is taken every cycle (busy stays low) and
// its result appears on the o_ ports with o_strobe high, in order, once
// it has passed the cell chains: 64 division cells (one quotient bit
// each), 30 fraction cells (one bit of 1e9 each) and two adder stages.
// The receiver cannot stall the block, so it must take every strobed
// result in the cycle it appears. failed is high, with duration zero,
// for zero bandwidth or any 64-bit overflow.
module ceil_scaled_transfer_time_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_byte_count,
    input  logic [63:0] i_bytes_per_second,
    input  logic [63:0] i_fixed_latency,
    output logic        o_strobe,
    output logic [63:0] o_duration,
    output logic        o_failed
);
    import cstt_pkg::*;

    t_div_stage  w_div  [0:DATA_W];
    t_frac_stage w_frac [0:SCALE_BITS];

    // launch a transfer into the division chain
    always_comb begin
        w_div[0].vld = start;
        w_div[0].nq  = i_byte_count;
        w_div[0].den = i_bytes_per_second;
        w_div[0].rem = '0;
        w_div[0].lat = i_fixed_latency;
    end

    for (genvar g = 0; g < DATA_W; g++) begin : g_div
        cstt_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_div[g]),
            .o_stage (w_div[g+1])
        );
    end

    // hand off quotient and remainder; flag zero bandwidth and whole overflow
    always_comb begin
        w_frac[0].vld   = w_div[DATA_W].vld;
        w_frac[0].bad   = (w_div[DATA_W].den == '0) || (w_div[DATA_W].nq > MAX_WHOLE);
        w_frac[0].den   = w_div[DATA_W].den;
        w_frac[0].rem   = w_div[DATA_W].rem;
        w_frac[0].acc   = '0;
        w_frac[0].fq    = '0;
        w_frac[0].whole = w_div[DATA_W].nq[WHOLE_W-1:0];
        w_frac[0].ws    = '0;
        w_frac[0].lat   = w_div[DATA_W].lat;
    end

    // walk the bits of 1e9 from the most significant down
    for (genvar k = 0; k < SCALE_BITS; k++) begin : g_frac
        cstt_frac_cell #(
            .ADD_BIT (NS_PER_SEC[SCALE_BITS-1-k])
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_frac[k]),
            .o_stage (w_frac[k+1])
        );
    end

    // stage A: round the fraction up and add it to the scaled whole part
    logic            r_a_vld;
    logic            r_a_bad;
    logic [63:0]     r_a_sum;
    logic [63:0]     r_a_lat;
    logic [DATA_W:0] w_sum1;
    logic [DATA_W:0] w_sum2;

    assign w_sum1 = {1'b0, w_frac[SCALE_BITS].ws}
                  + {{(DATA_W+1-SCALE_BITS){1'b0}}, w_frac[SCALE_BITS].fq}
                  + {{DATA_W{1'b0}}, (w_frac[SCALE_BITS].acc != '0)};

    always_ff @(posedge i_clk) begin
        r_a_bad <= w_frac[SCALE_BITS].bad | w_sum1[DATA_W];
        r_a_sum <= w_sum1[DATA_W-1:0];
        r_a_lat <= w_frac[SCALE_BITS].lat;
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_frac[SCALE_BITS].vld;
        end
    end

    // stage B: add the latency, zero the duration on any error
    assign w_sum2 = {1'b0, r_a_sum} + {1'b0, r_a_lat};

    logic        r_strobe;
    logic [63:0] r_duration;
    logic        r_failed;

    always_ff @(posedge i_clk) begin
        r_failed   <= r_a_bad | w_sum2[DATA_W];
        r_duration <= (r_a_bad | w_sum2[DATA_W]) ? '0 : w_sum2[DATA_W-1:0];
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_a_vld;
        end
    end

    assign busy       = 1'b0;
    assign o_strobe   = r_strobe;
    assign o_duration = r_duration;
    assign o_failed   = r_failed;

endmodule

@@ rtl/core/cstt_div_cell.sv @@
// ----------------------------------------------------------------------------
// cstt_div_cell: one restoring division step
// Retires one quotient bit per cycle and hands the record to the next cell.
// ----------------------------------------------------------------------------
module cstt_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cstt_pkg::t_div_stage i_stage,
    output cstt_pkg::t_div_stage o_stage
);
    import cstt_pkg::*;

    t_div_stage      r_stage;
    t_div_stage      n_stage;
    logic [DATA_W:0] w_trial;
    logic [DATA_W:0] w_diff;

    always_comb begin
        n_stage = i_stage;
        w_trial = {i_stage.rem, i_stage.nq[DATA_W-1]};
        w_diff  = w_trial - {1'b0, i_stage.den};
        if (w_trial >= {1'b0, i_stage.den}) begin
            n_stage.rem = w_diff[DATA_W-1:0];
            n_stage.nq  = {i_stage.nq[DATA_W-2:0], 1'b1};
        end else begin
            n_stage.rem = w_trial[DATA_W-1:0];
            n_stage.nq  = {i_stage.nq[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/core/cstt_frac_cell.sv @@
// ----------------------------------------------------------------------------
// cstt_frac_cell: one step of the modular scale walk
// Doubles the residue, adds the remainder when this scale bit is set, and
// advances the whole-part product by the same bit.
// ----------------------------------------------------------------------------
module cstt_frac_cell #(
    parameter bit ADD_BIT = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cstt_pkg::t_frac_stage i_stage,
    output cstt_pkg::t_frac_stage o_stage
);
    import cstt_pkg::*;

    t_frac_stage           r_stage;
    t_frac_stage           n_stage;
    logic [DATA_W-1:0]     w_gap;
    logic [DATA_W-1:0]     w_room;
    logic [DATA_W-1:0]     w_acc1;
    logic                  w_c1;
    logic                  w_c2;

    always_comb begin
        n_stage = i_stage;
        w_gap   = i_stage.den - i_stage.acc;
        w_room  = i_stage.den - i_stage.rem;
        // double the residue modulo den
        if (i_stage.acc >= w_gap) begin
            w_acc1 = i_stage.acc - w_gap;
            w_c1   = 1'b1;
        end else begin
            w_acc1 = {i_stage.acc[DATA_W-2:0], 1'b0};
            w_c1   = 1'b0;
        end
        // add the remainder modulo den
        w_c2        = 1'b0;
        n_stage.acc = w_acc1;
        if (ADD_BIT) begin
            if (w_acc1 >= w_room) begin
                n_stage.acc = w_acc1 - w_room;
                w_c2        = 1'b1;
            end else begin
                n_stage.acc = w_acc1 + i_stage.rem;
            end
        end
        n_stage.fq = {i_stage.fq[SCALE_BITS-2:0], 1'b0}
                   + {{(SCALE_BITS-1){1'b0}}, w_c1}
                   + {{(SCALE_BITS-1){1'b0}}, w_c2};
        n_stage.ws = {i_stage.ws[DATA_W-2:0], 1'b0}
                   + (ADD_BIT ? {{(DATA_W-WHOLE_W){1'b0}}, i_stage.whole}
                              : {DATA_W{1'b0}});
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ tb/sv/ceil_scaled_transfer_time_core_test.sv @@
// ----------------------------------------------------------------------------
// ceil_scaled_transfer_time_core_test: self-checking bench for the core
// Drives transfer queries through the start/busy handshake with random gaps,
// predicts ceil(bytes * 1e9 / bandwidth) + latency and the error flag with
// wide arithmetic, and compares every strobed result in order.
// ----------------------------------------------------------------------------

// Holds the expected durations in transfer order and checks results against them.
class transfer_time_board;

    typedef struct {
        logic [63:0] duration;
        logic        failed;
    } t_expected_time;

    t_expected_time pending[$];

    // Predict the duration for one query; zero duration with failed on error.
    function t_expected_time predict(logic [63:0] bytes, logic [63:0] bw, logic [63:0] lat);
        t_expected_time res;
        logic [63:0]  whole;
        logic [63:0]  rest;
        logic [127:0] scaled;
        logic [127:0] frac;
        logic [64:0]  sum;
        res.duration = '0;
        res.failed   = 1'b1;
        if (bw == 0) return res;
        whole = bytes / bw;
        rest  = bytes % bw;
        if (whole > cstt_pkg::MAX_WHOLE) return res;
        // fraction below 1e9, rounded up when a residue is left
        scaled = 128'(rest) * 128'(cstt_pkg::NS_PER_SEC);
        frac   = scaled / 128'(bw);
        if (scaled % 128'(bw) != 0) frac = frac + 1;
        sum = 65'(whole * cstt_pkg::NS_PER_SEC) + 65'(frac[63:0]);
        if (sum[64]) return res;
        sum = 65'(sum[63:0]) + 65'(lat);
        if (sum[64]) return res;
        res.duration = sum[63:0];
        res.failed   = 1'b0;
        return res;
    endfunction

    function void note_transfer(logic [63:0] bytes, logic [63:0] bw, logic [63:0] lat);
        pending.push_back(predict(bytes, bw, lat));
    endfunction

    // Return 1 when the result matches the oldest expectation; describe any miss.
    function bit check_result(logic [63:0] duration, logic failed, output string why);
        t_expected_time exp_t;
        why = "";
        if (pending.size() == 0) begin
            why = $sformatf("unexpected result duration=%0d failed=%0b", duration, failed);
            return 0;
        end
        exp_t = pending.pop_front();
        if (duration !== exp_t.duration || failed !== exp_t.failed) begin
            why = $sformatf("duration=%0d failed=%0b, wanted duration=%0d failed=%0b",
                            duration, failed, exp_t.duration, exp_t.failed);
            return 0;
        end
        return 1;
    endfunction

    function int outstanding();
        return pending.size();
    endfunction

endclass

module ceil_scaled_transfer_time_core_test;

    localparam logic [63:0] ALL_ONES  = '1;
    localparam int          LATENCY   = 96;
    localparam int          N_RANDOM  = 1200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_byte_count = '0;
    logic [63:0] i_bytes_per_second = '0;
    logic [63:0] i_fixed_latency = '0;
    logic        o_strobe;
    logic [63:0] o_duration;
    logic        o_failed;

    int                   n_errors = 0;
    transfer_time_board   board = new();

    always #4 i_clk = ~i_clk;

    ceil_scaled_transfer_time_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_byte_count       (i_byte_count),
        .i_bytes_per_second (i_bytes_per_second),
        .i_fixed_latency    (i_fixed_latency),
        .o_strobe           (o_strobe),
        .o_duration         (o_duration),
        .o_failed           (o_failed)
    );

    task automatic report(string why);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, why);
    endtask

    // Check every strobed result at the edge that ends its cycle.
    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && o_strobe) begin
            if (!board.check_result(o_duration, o_failed, why)) report(why);
        end
    end

    // Send one transfer. Entered and left at a falling edge; start stays high
    // when the next transfer follows without a gap.
    task automatic send(logic [63:0] bytes, logic [63:0] bw, logic [63:0] lat, int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_byte_count       = bytes;
        i_bytes_per_second = bw;
        i_fixed_latency    = lat;
        start              = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_transfer(bytes, bw, lat);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Pick a random query, biased toward the error boundaries.
    task automatic send_random(int gap);
        logic [63:0] bytes;
        logic [63:0] bw;
        logic [63:0] lat;
        case ($urandom_range(0, 7))
            0: begin
                // whole part at or near the largest value that still scales
                bw    = 64'($urandom_range(1, 900));
                bytes = (cstt_pkg::MAX_WHOLE - 64'($urandom_range(0, 1))) * bw
                        + 64'($urandom_range(0, 899)) % bw;
            end
            1: begin
                bw    = 64'($urandom_range(1, 1000));
                bytes = rand64();
            end
            2: begin
                bw    = ($urandom_range(0, 15) == 0) ? '0 : rand64();
                bytes = rand64();
            end
            3: begin
                bw    = rand64() >> $urandom_range(0, 63);
                bytes = rand64() >> $urandom_range(0, 63);
            end
            default: begin
                bw    = 64'($urandom_range(1, 32'hffff_ffff));
                bytes = rand64() >> $urandom_range(16, 40);
            end
        endcase
        case ($urandom_range(0, 3))
            0:       lat = rand64();
            1:       lat = ALL_ONES - 64'($urandom_range(0, 32'hffff_ffff));
            default: lat = 64'($urandom_range(0, 100000));
        endcase
        send(bytes, bw, lat, gap);
    endtask

    initial begin
        int gap_mode;
        int gap;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: extremes and each error path
        send('0, 64'd1, '0, 0);                                // zero time
        send(64'd1, '0, 64'd5, 0);                             // zero bandwidth
        send(ALL_ONES, '0, ALL_ONES, 0);
        send(ALL_ONES, 64'd1, '0, 2);                          // whole too large
        send(cstt_pkg::MAX_WHOLE, 64'd1, '0, 0);               // largest whole
        send(cstt_pkg::MAX_WHOLE + 1, 64'd1, '0, 0);
        send(cstt_pkg::MAX_WHOLE * 3 + 2, 64'd3, '0, 1);       // fraction just fits
        send(cstt_pkg::MAX_WHOLE * 4 + 3, 64'd4, '0, 0);       // fraction overflows
        send(cstt_pkg::MAX_WHOLE, 64'd1, 64'd709551615, 0);    // latency just fits
        send(cstt_pkg::MAX_WHOLE, 64'd1, 64'd709551616, 0);    // latency overflows
        send('0, 64'd1, ALL_ONES, 3);
        send(64'd1, 64'd1, ALL_ONES, 0);
        send(64'd1, ALL_ONES, '0, 0);                          // tiny residue rounds up
        send(ALL_ONES - 1, ALL_ONES, '0, 0);
        send(ALL_ONES, ALL_ONES, 64'd7, 0);
        send(64'd1, 64'd3, '0, 0);
        send(64'd1000, 64'd1000000000, '0, 0);                 // exact, no rounding
        send(64'd123456789, 64'd1000, 64'd42, 13);
        send(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        send(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0);

        // random: alternate stretches of back-to-back and gapped transfers
        gap_mode = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) gap_mode = $urandom_range(0, 2);
            if (n == N_RANDOM / 2) begin
                // drain: hold off until every result is in
                start = 1'b0;
                while (board.outstanding() != 0) @(negedge i_clk);
            end
            case (gap_mode)
                0:       gap = 0;
                1:       gap = $urandom_range(0, 13);
                default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
            endcase
            send_random(gap);
        end
        start = 1'b0;

        while (board.outstanding() != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("ceil_scaled_transfer_time_core_test: clean");
        end else begin
            $display("ceil_scaled_transfer_time_core_test: errors");
        end
        $finish;
    end

    // Guard against a hung handshake or missing results.
    initial begin
        #2000000;
        $display("ceil_scaled_transfer_time_core_test: errors");
        $finish;
    end

endmodule
